// ===== sv/fdl_pkg.sv =====
package fdl_pkg;

  typedef enum logic [2:0] {
    MODE_PASS   = 3'd0,
    MODE_INT    = 3'd1,
    MODE_LINEAR = 3'd2,
    MODE_HERM   = 3'd3,
    MODE_SIX    = 3'd4
  } mode_t;

  localparam int unsigned CFG_IDX_MODE  = 0;
  localparam int unsigned CFG_IDX_BLOCK = 1;
  localparam int unsigned EXTRA_BITS    = 12;
  localparam int unsigned CFG_W         = 13;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CAPT,
    ST_COEF,
    ST_MUL,
    ST_FINAL,
    ST_OUT
  } state_t;

endpackage

// ===== sv/fdl_div.sv =====
// Restoring divider, one quotient bit per cycle; magnitude in, magnitude out.
module fdl_div
  import fdl_pkg::*;
#(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    trial    = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = !busy_r && !start;
  assign quo  = q_r;

endmodule

// ===== sv/fdl_mac.sv =====
// Shared Horner unit: acc <- floor((acc*f + half) >> F) + c, one step a cycle.
module fdl_mac
  import fdl_pkg::*;
#(
  parameter int unsigned ACC_W  = 40,
  parameter int unsigned FRAC_W = 16
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic                     step,
  input  logic signed [ACC_W-1:0]  c,
  input  logic        [FRAC_W-1:0] f,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic signed [ACC_W+FRAC_W:0]   prod;

  always_comb begin
    prod    = $signed({{(FRAC_W+1){acc_r[ACC_W-1]}}, acc_r})
              * $signed({1'b0, f})
              + $signed((ACC_W+FRAC_W+1)'(1) <<< (FRAC_W - 1));
    acc_nxt = acc_r;
    if (load)      acc_nxt = c;
    else if (step) acc_nxt = ACC_W'(prod >>> FRAC_W) + c;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== sv/fractional_delay_line.sv =====
// Variable fractional delay line. Each item writes sample_in into a DEPTH-entry
// circular buffer and returns one sample read at a delay that ramps linearly
// from the last target to target_delay over block_length items (latched when
// block_start is high), interpolated by interp_mode. After reset the buffer is
// cleared one entry per cycle, all DEPTH entries, before the first item is taken.
// Each item reads its taps through the single buffer read port, loads the
// first Horner coefficient, runs any remaining Horner steps on the shared
// Horner unit, rounds and saturates, and presents the result; a new item is
// taken only once that result has been taken. With block_start set, the
// ramp-step division runs first (one quotient bit per cycle).
module fractional_delay_line
  import fdl_pkg::*;
#(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic [FRAC_BITS+8:0]          in_target_delay,
  input  logic                          in_block_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_write_en,
  input  logic [0:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned DW     = FRAC_BITS + 9;
  localparam int unsigned RW     = DW + EXTRA_BITS;
  localparam int unsigned SW     = RW + 1;
  localparam int unsigned ACC_W  = SAMPLE_BITS + 16;
  localparam int unsigned NUM_W  = DW + EXTRA_BITS + 1;
  localparam logic [DW-1:0] LIMIT = DW'(((DEPTH / 2 - 6) << FRAC_BITS) - 1);
  localparam logic [RW-1:0] RMAX  = {LIMIT, {EXTRA_BITS{1'b1}}};

  state_t state_r, state_nxt;

  logic [2:0]       mode_r;
  logic [CFG_W-1:0] blen_r;
  logic [AW-1:0]    wp_r, clr_r, base_r;
  logic [DW-1:0]    cur_r;
  logic [RW-1:0]    run_r;
  logic signed [SW-1:0] step_r;
  logic             neg_r;
  logic signed [SAMPLE_BITS-1:0] x_r, res_r;
  logic [FRAC_BITS-1:0] f_r;
  logic [2:0]       k_r;
  logic signed [SAMPLE_BITS-1:0] tap_r [6];
  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_r;

  // ramp divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [CFG_W-1:0] div_den;
  logic [DW-1:0]    tgt_sat;
  logic signed [DW:0] diff;

  assign tgt_sat = (in_target_delay > LIMIT) ? LIMIT : in_target_delay;
  assign diff    = $signed({1'b0, tgt_sat}) - $signed({1'b0, cur_r});
  assign div_num = diff[DW] ? NUM_W'((~{diff, {EXTRA_BITS{1'b0}}}) + 1'b1)
                            : NUM_W'({diff, {EXTRA_BITS{1'b0}}});
  assign div_den = (blen_r == '0) ? CFG_W'(1) : blen_r;

  fdl_div #(.NUM_W(NUM_W), .DEN_W(CFG_W)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // Horner coefficients per step
  logic [2:0] hk_r;
  logic       mac_load, mac_step;
  logic signed [ACC_W-1:0] coef, acc;
  logic signed [ACC_W-1:0] a, b, c, e, g, h;

  assign a = ACC_W'(tap_r[0]);
  assign b = ACC_W'(tap_r[1]);
  assign c = ACC_W'(tap_r[2]);
  assign e = ACC_W'(tap_r[3]);
  assign g = ACC_W'(tap_r[4]);
  assign h = ACC_W'(tap_r[5]);

  always_comb begin
    coef = '0;
    if (mode_r == MODE_HERM) begin
      unique case (hk_r)
        3'd0:    coef = (e - a) + 3 * (b - c);
        3'd1:    coef = 2 * a - 5 * b + 4 * c - e;
        3'd2:    coef = c - a;
        default: coef = 2 * b;
      endcase
    end else if (mode_r == MODE_SIX) begin
      unique case (hk_r)
        3'd0: coef = -5 * a + 25 * b - 50 * c + 50 * e - 25 * g + 5 * h;
        3'd1: coef = 13 * a - 64 * b + 126 * c - 124 * e + 61 * g - 12 * h;
        3'd2: coef = -9 * a + 39 * b - 70 * c + 66 * e - 33 * g + 7 * h;
        3'd3: coef = -a + 16 * b - 30 * c + 16 * e - g;
        3'd4: coef = 2 * a - 16 * b + 16 * e - 2 * g;
        default: coef = 24 * c;
      endcase
    end else begin
      // linear as a two-step Horner: (far-near)*f + near
      unique case (hk_r)
        3'd0:    coef = b - a;
        default: coef = a;
      endcase
    end
  end

  fdl_mac #(.ACC_W(ACC_W), .FRAC_W(FRAC_BITS)) u_mac (
    .clk, .load(mac_load), .step(mac_step), .c(coef), .f(f_r), .acc(acc)
  );

  logic [2:0] ntaps, nsteps;
  always_comb begin
    unique case (mode_r)
      MODE_INT:    begin ntaps = 3'd1; nsteps = 3'd0; end
      MODE_LINEAR: begin ntaps = 3'd2; nsteps = 3'd1; end
      MODE_HERM:   begin ntaps = 3'd4; nsteps = 3'd3; end
      MODE_SIX:    begin ntaps = 3'd6; nsteps = 3'd5; end
      default:     begin ntaps = 3'd0; nsteps = 3'd0; end
    endcase
  end

  // final rounding and saturation
  localparam int unsigned QW  = SAMPLE_BITS + 3;
  localparam int unsigned RSH = SAMPLE_BITS + 4;
  localparam logic signed [QW-1:0] XLIM = QW'((64'sd3 <<< (SAMPLE_BITS - 1)) + 3);
  localparam logic signed [QW:0] RECIP = (QW+1)'(((64'sd1 <<< RSH) + 2) / 3);

  logic signed [ACC_W-1:0] fin, adj, x8;
  logic signed [QW-1:0] xq, q3;
  logic signed [QW:0] rem3;
  logic signed [2*QW:0] qprod;
  logic signed [SAMPLE_BITS-1:0] sat_res;
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - 1;

  always_comb begin
    adj   = acc + ACC_W'(12);
    x8    = adj >>> 3;
    xq    = '0;
    q3    = '0;
    rem3  = '0;
    qprod = '0;
    if (mode_r == MODE_HERM) begin
      fin = (acc + ACC_W'(1)) >>> 1;
    end else if (mode_r == MODE_SIX) begin
      // round divide by 24: +12, >>3, clamp to just past the output range, then /3
      // by reciprocal with a one-step fix-up
      if (x8 > ACC_W'(XLIM))       xq = XLIM;
      else if (x8 < -ACC_W'(XLIM)) xq = -XLIM;
      else                         xq = QW'(x8);
      qprod = xq * RECIP;
      q3    = QW'(qprod >>> RSH);
      rem3  = (QW+1)'(xq) - (QW+1)'(q3) - (QW+1)'(q3 <<< 1);
      if (rem3 < 0)       q3 = q3 - QW'(1);
      else if (rem3 >= 3) q3 = q3 + QW'(1);
      fin = ACC_W'(q3);
    end else begin
      fin = acc;
    end
    if (fin > SMAX)      sat_res = SAMPLE_BITS'(SMAX);
    else if (fin < SMIN) sat_res = SAMPLE_BITS'(SMIN);
    else                 sat_res = SAMPLE_BITS'(fin);
  end

  logic accept;
  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = in_block_start ? ST_DIV : ST_READ;
      ST_DIV:   if (div_done) state_nxt = ST_READ;
      ST_READ:  if (k_r == ntaps) state_nxt = ST_CAPT;
      ST_CAPT:  state_nxt = ST_COEF;
      ST_COEF:  state_nxt = (nsteps == 3'd0) ? ST_FINAL : ST_MUL;
      ST_MUL:   if (hk_r == nsteps) state_nxt = ST_FINAL;
      ST_FINAL: state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    div_start = accept && in_block_start;
    mac_load  = (state_r == ST_COEF);
    mac_step  = (state_r == ST_MUL);
  end

  logic [AW-1:0] wp_dec;
  logic [RW-1:0] run_sel;
  logic signed [SW+1:0] run_sum;
  assign wp_dec  = wp_r - 1'b1;
  assign run_sum = $signed({3'b0, run_r}) + (SW+2)'(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      mode_r  <= MODE_HERM;
      blen_r  <= CFG_W'(64);
      wp_r    <= '0;
      cur_r   <= '0;
      run_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write_en) begin
        if (cfg_index == 1'(CFG_IDX_MODE)) mode_r <= cfg_data[2:0];
        else                               blen_r <= cfg_data;
      end
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (accept) begin
        wp_r <= wp_dec;
        if (in_block_start) begin
          run_r <= {cur_r, {EXTRA_BITS{1'b0}}};
          cur_r <= tgt_sat;
        end
      end
      if (state_r == ST_DIV && div_done)
        step_r <= neg_r ? -$signed(SW'(div_quo)) : $signed(SW'(div_quo));
      if (state_r == ST_FINAL) begin
        if (run_sum < 0)                          run_r <= '0;
        else if (run_sum > $signed({3'b0, RMAX})) run_r <= RMAX;
        else                                      run_r <= RW'(run_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r   <= in_sample_in;
      neg_r <= diff[DW];
    end
    if (state_r == ST_CLEAR) mem[clr_r] <= '0;
    else if (accept)         mem[wp_dec] <= in_sample_in;
    rd_r <= mem[AW'(base_r + AW'(k_r))];
    if (state_r == ST_IDLE || state_r == ST_DIV) begin
      k_r    <= '0;
      f_r    <= run_r[EXTRA_BITS +: FRAC_BITS];
      // in idle the write pointer advances at this very edge when an item is accepted
      base_r <= ((state_r == ST_IDLE) ? wp_dec : wp_r) + AW'(run_r[RW-1 -: 9]);
    end
    if (state_r == ST_READ) begin
      k_r <= k_r + 1'b1;
      if (k_r != 3'd0) tap_r[k_r - 3'd1] <= rd_r;
    end
    if (state_r == ST_COEF) hk_r <= 3'd1;
    else if (state_r == ST_MUL) hk_r <= hk_r + 1'b1;
    else if (state_r != ST_CAPT) hk_r <= '0;
    if (state_r == ST_CAPT) hk_r <= '0;
    if (state_r == ST_FINAL) begin
      if (mode_r == MODE_INT) res_r <= tap_r[0];
      else if (mode_r == MODE_LINEAR || mode_r == MODE_HERM || mode_r == MODE_SIX)
        res_r <= sat_res;
      else res_r <= x_r;
    end
  end

  assign out_sample_out = res_r;

endmodule
